// ===== rtl/hsp_pkg.sv =====
// Shared types and constants of the Huffman symbol packer.
package hsp_pkg;

  localparam int MAX_CODE_LEN = 23;
  localparam int GROUP_BITS   = 6;

  localparam int FUNC_W      = 2;
  localparam int SYM_W       = 8;
  localparam int CODE_W      = 23;
  localparam int LEN_W       = 5;
  localparam int VALUE_W     = 6;
  localparam int TABLE_DEPTH = 1 << SYM_W;

  // Pending bits never exceed one short group plus the longest code.
  localparam int ACC_W = GROUP_BITS - 1 + MAX_CODE_LEN;
  localparam int CNT_W = $clog2(ACC_W + 1);
  localparam int PAD_W = $clog2(GROUP_BITS + 1);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_FLUSH  = 2'd2
  } func_e;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_PAD  = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } entry_t;

  // Looked-up item handed from the table stage to the emitter.
  typedef struct packed {
    logic              valid;
    logic [FUNC_W-1:0] func;
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0]  len;
  } stage_t;

endpackage

// ===== rtl/hsp_in_if.sv =====
// Input channel of the packer: load, encode and flush items.
interface hsp_in_if import hsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [SYM_W-1:0]  symbol;
  logic [CODE_W-1:0] code_bits;
  logic [LEN_W-1:0]  code_length;

  modport source (output valid, func, symbol, code_bits, code_length, input ready);
  modport sink   (input valid, func, symbol, code_bits, code_length, output ready);
endinterface

// ===== rtl/hsp_out_if.sv =====
// Result channel of the packer: packed groups and pad counts.
interface hsp_out_if import hsp_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] value;
  logic               kind;
  logic               last;

  modport source (output valid, value, kind, last, input ready);
  modport sink   (input valid, value, kind, last, output ready);
endinterface

// ===== rtl/huffman_symbol_packer.sv =====
// Top level of the Huffman symbol packer: code table and group emitter.
//
//   channel  dir  payload                               accepted when
//   sym_i    in   func, symbol, code_bits, code_length  valid && ready
//   res_o    out  value, kind, last                     valid && ready
//
// An item is taken into the input register, with the code table read there;
// the emitter then gives one result per cycle unless the result is stalled,
// so an encode releases up to four groups, possibly none, and a flush two.
// The single result register sets that rate. Reset empties the accumulator;
// the table holds no valid state and must be loaded before use. A stalled
// result holds the emitter, which in turn holds the input register.
module huffman_symbol_packer import hsp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  hsp_in_if.sink    sym_i,
  hsp_out_if.source res_o
);

  stage_t stage;
  logic   take;

  hsp_code_table u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .sym_i   (sym_i),
    .take_i  (take),
    .stage_o (stage)
  );

  hsp_group_emitter u_emitter (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (stage),
    .take_o  (take),
    .res_o   (res_o)
  );

endmodule

// ===== rtl/hsp_code_table.sv =====
// Code table memory and input stage register of the packer.
module hsp_code_table import hsp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  hsp_in_if.sink sym_i,
  input  logic   take_i,
  output stage_t stage_o
);

  entry_t            mem [TABLE_DEPTH];
  entry_t            rd_q;
  logic              valid_q;
  logic [FUNC_W-1:0] func_q;
  logic              accept;
  logic [LEN_W-1:0]  len_sat;
  logic [CODE_W-1:0] code_mask;
  entry_t            wr_entry;

  assign sym_i.ready = !valid_q || take_i;
  assign accept      = sym_i.valid && sym_i.ready;

  // Saturate the length and drop code bits above it.
  always_comb begin
    if (sym_i.code_length > LEN_W'(MAX_CODE_LEN)) begin
      len_sat = LEN_W'(MAX_CODE_LEN);
    end else begin
      len_sat = sym_i.code_length;
    end
    code_mask     = ~({CODE_W{1'b1}} << len_sat);
    wr_entry.code = sym_i.code_bits & code_mask;
    wr_entry.len  = len_sat;
  end

  always_ff @(posedge clk_i) begin
    if (accept && (func_e'(sym_i.func) == FUNC_LOAD)) begin
      mem[sym_i.symbol] <= wr_entry;
    end
    if (accept) begin
      rd_q   <= mem[sym_i.symbol];
      func_q <= sym_i.func;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (sym_i.ready) begin
      valid_q <= sym_i.valid;
    end
  end

  assign stage_o.valid = valid_q;
  assign stage_o.func  = func_q;
  assign stage_o.code  = rd_q.code;
  assign stage_o.len   = rd_q.len;

endmodule

// ===== rtl/hsp_group_emitter.sv =====
// Bit accumulator and result register: one group or pad count per cycle while the result is not stalled.
module hsp_group_emitter import hsp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  stage_t     stage_i,
  output logic       take_o,
  hsp_out_if.source  res_o
);

  localparam logic [ACC_W-1:0] GRP_MASK = ACC_W'((1 << GROUP_BITS) - 1);

  logic [ACC_W-1:0]   acc_q, acc_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               pad_pend_q, pad_pend_d;
  logic [PAD_W-1:0]   pad_q, pad_d;
  logic               out_valid_q, out_valid_d;
  logic [VALUE_W-1:0] value_q, value_d;
  logic               kind_q, kind_d;
  logic               last_q, last_d;

  logic               slot_free;
  logic [ACC_W-1:0]   app_acc;
  logic [CNT_W-1:0]   app_cnt;
  logic               use_app;
  logic [ACC_W-1:0]   grp_acc;
  logic [CNT_W-1:0]   grp_cnt;
  logic [CNT_W-1:0]   grp_rest;
  logic [VALUE_W-1:0] grp_val;
  logic [ACC_W-1:0]   grp_left;
  logic [CNT_W-1:0]   flush_pad;
  logic [VALUE_W-1:0] flush_val;

  assign slot_free = !out_valid_q || res_o.ready;

  always_comb begin
    app_acc  = (acc_q << stage_i.len) | ACC_W'(stage_i.code);
    app_cnt  = cnt_q + CNT_W'(stage_i.len);
    use_app  = cnt_q < CNT_W'(GROUP_BITS);
    grp_acc  = use_app ? app_acc : acc_q;
    grp_cnt  = use_app ? app_cnt : cnt_q;
    grp_rest = grp_cnt - CNT_W'(GROUP_BITS);
    grp_val  = VALUE_W'((grp_acc >> grp_rest) & GRP_MASK);
    grp_left = grp_acc & ~({ACC_W{1'b1}} << grp_rest);
    flush_pad = CNT_W'(GROUP_BITS) - cnt_q;
    flush_val = VALUE_W'((acc_q << flush_pad) & GRP_MASK);
  end

  always_comb begin
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    pad_pend_d  = pad_pend_q;
    pad_d       = pad_q;
    value_d     = value_q;
    kind_d      = kind_q;
    last_d      = last_q;
    out_valid_d = slot_free ? 1'b0 : out_valid_q;
    take_o      = 1'b0;

    priority if (cnt_q >= CNT_W'(GROUP_BITS)) begin
      // Drain the groups still pending from the last encode.
      if (slot_free) begin
        out_valid_d = 1'b1;
        value_d     = grp_val;
        kind_d      = KIND_DATA;
        last_d      = grp_rest < CNT_W'(GROUP_BITS);
        acc_d       = grp_left;
        cnt_d       = grp_rest;
      end
    end else if (pad_pend_q) begin
      if (slot_free) begin
        out_valid_d = 1'b1;
        value_d     = VALUE_W'(pad_q);
        kind_d      = KIND_PAD;
        last_d      = 1'b1;
        pad_pend_d  = 1'b0;
      end
    end else if (stage_i.valid) begin
      unique case (func_e'(stage_i.func))
        FUNC_ENCODE: begin
          if (app_cnt < CNT_W'(GROUP_BITS)) begin
            take_o = 1'b1;
            acc_d  = app_acc;
            cnt_d  = app_cnt;
          end else if (slot_free) begin
            take_o      = 1'b1;
            out_valid_d = 1'b1;
            value_d     = grp_val;
            kind_d      = KIND_DATA;
            last_d      = grp_rest < CNT_W'(GROUP_BITS);
            acc_d       = grp_left;
            cnt_d       = grp_rest;
          end
        end
        FUNC_FLUSH: begin
          if (slot_free) begin
            take_o      = 1'b1;
            out_valid_d = 1'b1;
            value_d     = flush_val;
            kind_d      = KIND_DATA;
            last_d      = 1'b0;
            pad_pend_d  = 1'b1;
            pad_d       = PAD_W'(flush_pad);
            acc_d       = '0;
            cnt_d       = '0;
          end
        end
        default: begin
          // Loads are already in the table; drop them and unused codes.
          take_o = 1'b1;
        end
      endcase
    end else begin
      // Idle: hold everything.
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cnt_q       <= '0;
      pad_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      pad_pend_q  <= pad_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pad_q   <= pad_d;
    value_q <= value_d;
    kind_q  <= kind_d;
    last_q  <= last_d;
  end

  assign res_o.valid = out_valid_q;
  assign res_o.value = value_q;
  assign res_o.kind  = kind_q;
  assign res_o.last  = last_q;

endmodule

// ===== sim/huffman_symbol_packer_test.sv =====
// Self-checking testbench of the Huffman symbol packer: directed and random items.
module huffman_symbol_packer_test;
  import hsp_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  localparam int PHASE_ITEMS     = 80;
  localparam int PRESSURE_ITEMS  = 40;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int SETTLE_CYCLES   = 20;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [SYM_W-1:0]  symbol;
    logic [CODE_W-1:0] code_bits;
    logic [LEN_W-1:0]  code_length;
  } sym_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               kind;
    logic               last;
  } group_t;

  logic clk_i;
  logic rst_ni;

  hsp_in_if  sym_if ();
  hsp_out_if res_if ();

  huffman_symbol_packer dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sym_i  (sym_if),
    .res_o  (res_if)
  );

  sym_item_t        pending_items[$];
  group_t           expected_groups[$];

  // Own copy of the packer state
  entry_t           code_book [TABLE_DEPTH];
  logic [ACC_W-1:0] held_bits  = '0;
  int               held_count = 0;

  // Entries that the stimulus has already loaded
  bit               loaded [TABLE_DEPTH];
  logic [SYM_W-1:0] loaded_syms[$];

  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  int     mismatch_count = 0;
  int     hold_left;
  bit     hold_taken;
  logic   hold_request   = 1'b0;
  int     quiet_cycles;
  group_t got;
  group_t want;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch: %s", what);
    mismatch_count++;
  endtask

  task automatic queue_item(input logic [FUNC_W-1:0] op, input int sym, input int code,
                            input int len);
    sym_item_t it;
    it.func        = op;
    it.symbol      = SYM_W'(sym);
    it.code_bits   = CODE_W'(code);
    it.code_length = LEN_W'(len);
    pending_items.push_back(it);
    if (op == FUNC_LOAD && !loaded[it.symbol]) begin
      loaded[it.symbol] = 1'b1;
      loaded_syms.push_back(it.symbol);
    end
  endtask

  // Mostly encodes of loaded bytes, with reloads, flushes and the odd unused item
  task automatic queue_random(input int count);
    int made;
    int roll;
    int len;
    made = 0;
    while (made < count) begin
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        queue_item(FUNC_UNUSED, $urandom_range(0, TABLE_DEPTH - 1),
                   $urandom_range(0, (1 << CODE_W) - 1), $urandom_range(0, 31));
      end else begin
        if (roll < 18 || loaded_syms.size() == 0) begin
          roll = $urandom_range(0, 99);
          if (roll < 55)
            len = $urandom_range(1, 8);
          else if (roll < 88)
            len = $urandom_range(9, MAX_CODE_LEN);
          else
            len = $urandom_range(0, 31);
          queue_item(FUNC_LOAD, $urandom_range(0, TABLE_DEPTH - 1),
                     $urandom_range(0, (1 << CODE_W) - 1), len);
        end else if (roll < 28) begin
          queue_item(FUNC_FLUSH, $urandom_range(0, TABLE_DEPTH - 1),
                     $urandom_range(0, (1 << CODE_W) - 1), $urandom_range(0, 31));
        end else begin
          queue_item(FUNC_ENCODE, loaded_syms[$urandom_range(0, loaded_syms.size() - 1)],
                     $urandom_range(0, (1 << CODE_W) - 1), $urandom_range(0, 31));
        end
        made++;
      end
    end
  endtask

  // Work out the groups that one accepted item releases
  task automatic pack_item(input sym_item_t it);
    logic [63:0] acc;
    int          len;
    int          pad;
    acc = 64'(held_bits);
    case (it.func)
      FUNC_LOAD: begin
        len = (it.code_length > MAX_CODE_LEN) ? MAX_CODE_LEN : int'(it.code_length);
        code_book[it.symbol].len  = LEN_W'(len);
        code_book[it.symbol].code = it.code_bits & CODE_W'((64'd1 << len) - 1);
      end
      FUNC_ENCODE: begin
        len = code_book[it.symbol].len;
        acc = (acc << len) | 64'(code_book[it.symbol].code);
        held_count += len;
        while (held_count >= GROUP_BITS) begin
          held_count -= GROUP_BITS;
          expected_groups.push_back('{value: VALUE_W'(acc >> held_count), kind: KIND_DATA,
                                      last: held_count < GROUP_BITS});
          acc &= (64'd1 << held_count) - 1;
        end
        held_bits = ACC_W'(acc);
      end
      FUNC_FLUSH: begin
        pad = GROUP_BITS - held_count;
        expected_groups.push_back('{value: VALUE_W'(acc << pad), kind: KIND_DATA,
                                    last: 1'b0});
        expected_groups.push_back('{value: VALUE_W'(pad), kind: KIND_PAD, last: 1'b1});
        held_bits  = '0;
        held_count = 0;
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    while (pending_items.size() != 0 || expected_groups.size() != 0) @(posedge clk_i);
  endtask

  // Driver: hold an offered item until taken, otherwise offer the next or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_if.valid       <= 1'b0;
      sym_if.func        <= FUNC_LOAD;
      sym_if.symbol      <= '0;
      sym_if.code_bits   <= '0;
      sym_if.code_length <= '0;
    end else begin
      if (sym_if.valid && sym_if.ready)
        pack_item(pending_items.pop_front());
      if (!(sym_if.valid && !sym_if.ready)) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          sym_if.valid       <= 1'b1;
          sym_if.func        <= pending_items[0].func;
          sym_if.symbol      <= pending_items[0].symbol;
          sym_if.code_bits   <= pending_items[0].code_bits;
          sym_if.code_length <= pending_items[0].code_length;
        end else begin
          sym_if.valid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, taken once on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      hold_taken <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_request && !hold_taken) begin
      hold_left  <= HOLD_OFF_CYCLES;
      hold_taken <= 1'b1;
    end
  end

  // Monitor: compare each accepted group with the oldest expectation
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        got = '{value: res_if.value, kind: res_if.kind, last: res_if.last};
        if (expected_groups.size() == 0) begin
          report_mismatch($sformatf("unexpected group value %0d kind %0d last %0d",
                                    got.value, got.kind, got.last));
        end else begin
          want = expected_groups.pop_front();
          if (got.value !== want.value || got.kind !== want.kind || got.last !== want.last)
            report_mismatch($sformatf("got value %0d kind %0d last %0d, want %0d %0d %0d",
                                      got.value, got.kind, got.last,
                                      want.value, want.kind, want.last));
        end
      end
      res_if.ready <= (hold_left == 0) && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((sym_if.valid && sym_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("huffman_symbol_packer_test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Flush on an empty accumulator first, then table extremes
    queue_item(FUNC_FLUSH, 0, 0, 0);
    queue_item(FUNC_LOAD, 0, 23'h7FFFFF, MAX_CODE_LEN);
    queue_item(FUNC_LOAD, 255, 1, 1);
    queue_item(FUNC_LOAD, 1, 23'h05A5A5, 0);
    queue_item(FUNC_LOAD, 2, 23'h7FFFFF, 31);
    queue_item(FUNC_LOAD, 3, 23'h2AAAAD, 3);
    queue_item(FUNC_LOAD, 4, 23'h000015, GROUP_BITS);
    queue_item(FUNC_LOAD, 128, 23'h400000, MAX_CODE_LEN);
    // Two longest codes back to back; the second releases four groups
    queue_item(FUNC_ENCODE, 0, 0, 0);
    queue_item(FUNC_ENCODE, 0, 23'h7FFFFF, 31);
    queue_item(FUNC_ENCODE, 1, 0, 0);
    queue_item(FUNC_ENCODE, 255, 0, 0);
    queue_item(FUNC_ENCODE, 2, 0, 0);
    queue_item(FUNC_ENCODE, 3, 0, 0);
    queue_item(FUNC_FLUSH, 255, 23'h7FFFFF, 31);
    queue_item(FUNC_UNUSED, 0, 0, 0);
    queue_item(FUNC_UNUSED, 255, 23'h7FFFFF, 31);
    queue_item(FUNC_ENCODE, 4, 0, 0);
    queue_item(FUNC_FLUSH, 0, 0, 0);
    queue_item(FUNC_ENCODE, 128, 0, 0);
    queue_item(FUNC_ENCODE, 255, 0, 0);
    queue_item(FUNC_FLUSH, 0, 0, 0);
    drain();

    queue_random(PHASE_ITEMS);
    drain();
    send_idle_pct <= 87;
    queue_random(PHASE_ITEMS);
    drain();
    send_idle_pct  <= 0;
    recv_stall_pct <= 87;
    queue_random(PHASE_ITEMS);
    drain();
    send_idle_pct  <= 23;
    recv_stall_pct <= 23;
    queue_random(PHASE_ITEMS);
    drain();

    // Hold the result side off while items keep coming, so the input backs up
    send_idle_pct  <= 0;
    recv_stall_pct <= 0;
    hold_request   <= 1'b1;
    queue_random(PRESSURE_ITEMS);
    drain();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("huffman_symbol_packer_test passed");
    else
      $display("huffman_symbol_packer_test failed");
    $finish;
  end

endmodule
